FILE: hdl/hqp_pkg.sv
// Shared types, codes and sizes for the quadratic-probe hash table.
`default_nettype none

package hqp_pkg;

    localparam int KEY_W         = 31;
    localparam int VALUE_W       = 32;
    localparam int SIZE_W        = 5;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int MAX_SLOTS_DEF = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK
    } state_t;

    typedef enum logic [1:0] {
        MARK_EMPTY    = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_DELETED  = 2'd2
    } mark_t;

endpackage

`default_nettype wire

FILE: hdl/hqp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/hqp_mod_unit.sv
// Shared modular reduction step: one compare and subtract against the table size.
`default_nettype none

module hqp_mod_unit (
    input  wire logic [hqp_pkg::SIZE_W:0]   operand,
    input  wire logic [hqp_pkg::SIZE_W-1:0] size,
    output logic      [hqp_pkg::SIZE_W-1:0] result
);

    logic [hqp_pkg::SIZE_W:0] diff;

    // wherever the result is used the operand is below twice the size, so one subtraction suffices
    always_comb begin
        diff = operand - {1'b0, size};
        if (operand >= {1'b0, size}) begin
            result = diff[hqp_pkg::SIZE_W-1:0];
        end else begin
            result = operand[hqp_pkg::SIZE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hash_table_quadratic_probe_unit.sv
// Open-addressing hash table with quadratic probing: sequencer, slot marks and key/value store.
//
// Usage:
//   s_* carries one request per transfer: s_func (0 insert, 1 search, 2 delete), s_key, s_value.
//   m_* returns one result per request: m_status (0 ok, 1 full, 2 duplicate, 3 not found)
//   and m_found_value (stored value on a successful search, else zero).
//   cfg_* writes the size in use (slots probed); 0 acts as 1, values above the slot count clamp.
//   Write it only while no request is outstanding.
// Timing:
//   s_ready is high only while idle; one request is in flight at a time.
//   The home slot is key mod size, computed one key bit per cycle.
//   Each probe then runs a store read, then a check, through the shared mod unit;
//   a request takes 1 to the size in use probes, and the next request is taken once the
//   result is registered and the sequencer is back in idle.
// Reset (aresetn low, synchronous): all slots empty, count zero, table size 10, no result.
// Stall: a finished result waits in the output register; a following request runs its hashing
//   and first store read, then holds at its first probe check until m_ready drains the
//   earlier result.
`default_nettype none

module hash_table_quadratic_probe_unit #(
    parameter int MAX_SLOTS = hqp_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hqp_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [hqp_pkg::FUNC_W-1:0]          s_func,
    input  wire logic [hqp_pkg::KEY_W-1:0]           s_key,
    input  wire logic signed [hqp_pkg::VALUE_W-1:0]  s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [hqp_pkg::STATUS_W-1:0]             m_status,
    output logic signed [hqp_pkg::VALUE_W-1:0]       m_found_value
);

    localparam int SIZE_W    = hqp_pkg::SIZE_W;
    localparam int KEY_W     = hqp_pkg::KEY_W;
    localparam int VALUE_W   = hqp_pkg::VALUE_W;
    localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
    // the size register cannot reach beyond SIZE_MAX, so no slot above that is ever probed
    localparam int SLOT_DEPTH = (MAX_SLOTS < SIZE_MAX) ? MAX_SLOTS : SIZE_MAX;
    localparam int IDX_W     = $clog2(SLOT_DEPTH);
    localparam int WORD_W    = KEY_W + VALUE_W;

    hqp_pkg::state_t state_reg, state_next;

    logic [SIZE_W-1:0]          size_cfg_reg;
    logic [SIZE_W-1:0]          size_use;
    logic [hqp_pkg::FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [VALUE_W-1:0]         value_reg;
    logic [SIZE_W-1:0]          bit_reg, bit_next;
    logic [SIZE_W-1:0]          idx_reg, idx_next;
    logic [SIZE_W-1:0]          nidx_reg, nidx_next;
    logic [SIZE_W-1:0]          odd_reg, odd_next;
    logic [SIZE_W-1:0]          probe_reg, probe_next;
    logic [SIZE_W-1:0]          count_reg, count_next;
    hqp_pkg::mark_t             marks_reg [SLOT_DEPTH];

    logic                         m_valid_reg;
    logic [hqp_pkg::STATUS_W-1:0] m_status_reg;
    logic [VALUE_W-1:0]           m_found_value_reg;

    logic [SIZE_W:0]    unit_op;
    logic [SIZE_W-1:0]  unit_res;
    logic [IDX_W-1:0]   slot_addr;
    logic [WORD_W-1:0]  rd_word;
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    hqp_pkg::mark_t     cur_mark;
    logic               key_hit;
    logic               last_probe;
    logic               out_free;
    logic               accept;

    logic                         finish;
    logic [hqp_pkg::STATUS_W-1:0] fin_status;
    logic [VALUE_W-1:0]           fin_found;
    logic                         store_we;
    logic                         mark_we;
    hqp_pkg::mark_t               mark_val;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == hqp_pkg::ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_value_reg;

    always_comb begin
        if (size_cfg_reg == '0) begin
            size_use = SIZE_W'(1);
        end else if (size_cfg_reg > SIZE_W'(SLOT_DEPTH)) begin
            size_use = SIZE_W'(SLOT_DEPTH);
        end else begin
            size_use = size_cfg_reg;
        end
    end

    assign slot_addr  = idx_reg[IDX_W-1:0];
    assign rd_key     = rd_word[WORD_W-1:VALUE_W];
    assign rd_value   = rd_word[VALUE_W-1:0];
    assign cur_mark   = marks_reg[slot_addr];
    assign key_hit    = (rd_key == key_reg);
    assign last_probe = (probe_reg == size_use - SIZE_W'(1));
    assign out_free   = !m_valid_reg || m_ready;

    hqp_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOT_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(slot_addr),
        .wdata({key_reg, value_reg}),
        .raddr(slot_addr),
        .rdata(rd_word)
    );

    // Operand select for the shared reduction step
    always_comb begin
        case (state_reg)
            hqp_pkg::ST_HASH:      unit_op = {idx_reg, key_reg[bit_reg]};
            hqp_pkg::ST_PROBE_RD:  unit_op = {1'b0, idx_reg} + {1'b0, odd_reg};
            hqp_pkg::ST_PROBE_CHK: unit_op = {1'b0, odd_reg} + (SIZE_W+1)'(2);
            default:               unit_op = '0;
        endcase
    end

    hqp_mod_unit u_mod (
        .operand(unit_op),
        .size   (size_use),
        .result (unit_res)
    );

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        nidx_next  = nidx_reg;
        odd_next   = odd_reg;
        probe_next = probe_reg;
        count_next = count_reg;
        finish     = 1'b0;
        fin_status = hqp_pkg::STATUS_NOT_FOUND;
        fin_found  = '0;
        store_we   = 1'b0;
        mark_we    = 1'b0;
        mark_val   = hqp_pkg::MARK_OCCUPIED;

        unique case (state_reg)
            hqp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = hqp_pkg::ST_HASH;
                    bit_next   = SIZE_W'(KEY_W - 1);
                    idx_next   = '0;
                end
            end
            hqp_pkg::ST_HASH: begin
                // shift in one key bit, MSB first, reducing as we go
                idx_next = unit_res;
                if (bit_reg == '0) begin
                    state_next = hqp_pkg::ST_PROBE_RD;
                    probe_next = '0;
                    odd_next   = (size_use == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                end else begin
                    bit_next = bit_reg - SIZE_W'(1);
                end
            end
            hqp_pkg::ST_PROBE_RD: begin
                nidx_next  = unit_res;
                state_next = hqp_pkg::ST_PROBE_CHK;
            end
            hqp_pkg::ST_PROBE_CHK: begin
                if (out_free) begin
                    case (func_reg) inside
                        hqp_pkg::FUNC_INSERT: begin
                            if (count_reg >= size_use) begin
                                finish     = 1'b1;
                                fin_status = hqp_pkg::STATUS_FULL;
                            end else if (cur_mark != hqp_pkg::MARK_OCCUPIED) begin
                                finish     = 1'b1;
                                fin_status = hqp_pkg::STATUS_OK;
                                store_we   = 1'b1;
                                mark_we    = 1'b1;
                                mark_val   = hqp_pkg::MARK_OCCUPIED;
                                count_next = count_reg + SIZE_W'(1);
                            end else if (key_hit) begin
                                finish     = 1'b1;
                                fin_status = hqp_pkg::STATUS_DUPLICATE;
                            end else if (last_probe) begin
                                finish     = 1'b1;
                                fin_status = hqp_pkg::STATUS_FULL;
                            end
                        end
                        hqp_pkg::FUNC_SEARCH, hqp_pkg::FUNC_DELETE: begin
                            if (cur_mark == hqp_pkg::MARK_EMPTY) begin
                                finish = 1'b1;
                            end else if (cur_mark == hqp_pkg::MARK_OCCUPIED && key_hit) begin
                                finish     = 1'b1;
                                fin_status = hqp_pkg::STATUS_OK;
                                if (func_reg == hqp_pkg::FUNC_SEARCH) begin
                                    fin_found = rd_value;
                                end else begin
                                    mark_we  = 1'b1;
                                    mark_val = hqp_pkg::MARK_DELETED;
                                    if (count_reg != '0) begin
                                        count_next = count_reg - SIZE_W'(1);
                                    end
                                end
                            end else if (last_probe) begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase

                    if (finish) begin
                        state_next = hqp_pkg::ST_IDLE;
                    end else begin
                        // advance to the next quadratic offset
                        state_next = hqp_pkg::ST_PROBE_RD;
                        probe_next = probe_reg + SIZE_W'(1);
                        idx_next   = nidx_reg;
                        odd_next   = (size_use == SIZE_W'(1)) ? '0 : unit_res;
                    end
                end
            end
            default: begin
                state_next = hqp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hqp_pkg::ST_IDLE;
            size_cfg_reg <= hqp_pkg::SIZE_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOT_DEPTH; i++) begin
                marks_reg[i] <= hqp_pkg::MARK_EMPTY;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                size_cfg_reg <= cfg_data;
            end
            if (mark_we) begin
                marks_reg[slot_addr] <= mark_val;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg   <= bit_next;
        idx_reg   <= idx_next;
        nidx_reg  <= nidx_next;
        odd_reg   <= odd_next;
        probe_reg <= probe_next;
        if (accept) begin
            func_reg  <= s_func;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
        if (finish) begin
            m_status_reg      <= fin_status;
            m_found_value_reg <= fin_found;
        end
    end

    a_count_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SIZE_W'(SLOT_DEPTH))
        else $error("occupied count exceeds slot depth");

    a_idx_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hqp_pkg::ST_PROBE_RD || state_reg == hqp_pkg::ST_PROBE_CHK)
        |-> (idx_reg < size_use && odd_reg < size_use))
        else $error("probe slot or offset outside table size");

    a_accept_starts_hash : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == hqp_pkg::ST_HASH)
        else $error("accepted request did not start hashing");

    a_result_from_check : assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> $past(state_reg) == hqp_pkg::ST_PROBE_CHK)
        else $error("result raised outside probe check");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_status_reg)
        && $stable(m_found_value_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
